// File: design/brcs_pkg.sv
package brcs_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_RAW_W = $clog2(QUEUE_DEPTH + 1);
  // count is kept at least as wide as the reported queue_count field
  localparam int CNT_W = (CNT_RAW_W > 4) ? CNT_RAW_W : 4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_OPEN    = 3'd1,
    FUNC_CLOSE   = 3'd2,
    FUNC_DELAY   = 3'd3,
    FUNC_CLEAR   = 3'd4,
    FUNC_PWRFAIL = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_DELAY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REL_INDET  = 2'd0,
    REL_OPEN   = 2'd1,
    REL_CLOSED = 2'd2
  } relay_state_e;

  typedef enum logic {
    REG_MIN_VOLTAGE = 1'b0,
    REG_PULSE_MS    = 1'b1
  } reg_idx_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_EVAL = 1'b1
  } seq_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] len;
  } cmd_t;

  typedef struct packed {
    logic we;
    ptr_t waddr;
    cmd_t wdata;
    logic re;
    ptr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic         open_drive;
    logic         close_drive;
    relay_state_e relay_state;
    logic [3:0]   queue_count;
    logic         command_done;
    logic         rejected;
    logic         halted;
  } rsp_t;

  function automatic ptr_t next_ptr(ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

// File: design/brcs_if.sv
interface brcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] delay_ms;
  logic        adc_valid;
  logic [15:0] relay_voltage;

  modport source (output valid, func, delay_ms, adc_valid, relay_voltage, input ready);
  modport sink (input valid, func, delay_ms, adc_valid, relay_voltage, output ready);
endinterface

interface brcs_out_if;
  logic       valid;
  logic       ready;
  logic       open_drive;
  logic       close_drive;
  logic [1:0] relay_state;
  logic [3:0] queue_count;
  logic       command_done;
  logic       rejected;
  logic       halted;

  modport source (output valid, open_drive, close_drive, relay_state, queue_count,
                  command_done, rejected, halted, input ready);
  modport sink (input valid, open_drive, close_drive, relay_state, queue_count,
                command_done, rejected, halted, output ready);
endinterface

// File: design/bistable_relay_command_sequencer.sv
// Command queue for a bistable relay. Open, close and delay commands are
// queued in a small synchronous command memory (QUEUE_DEPTH entries, one
// registered read port) and the head command is worked off once per tick
// beat, one tick standing for one millisecond. Enqueue, clear and power-fail
// beats and, once halted, tick beats write the result register straight
// from the idle state; a tick beat while the block is not halted first reads
// the head entry from the command memory and then, in the evaluate state,
// evaluates it and writes the result register. Only one beat is
// in flight at a time, so a write of a new entry and the read of the head
// never land in the same cycle and no forwarding is needed. One result beat
// leaves for every input beat; a new beat is taken as soon as the result
// register is free or is being emptied in the same cycle. After a power fail
// the block drives the open coil, reports halted and ignores every beat until
// reset. The memory has no reset and no clearing pass: only counted entries
// are ever evaluated.
module bistable_relay_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  brcs_in_if.sink     cmd_i,
  brcs_out_if.source  rsp_o
);
  import brcs_pkg::*;

  // queue and execution state
  ptr_t         head_q, head_d;
  ptr_t         tail_q, tail_d;
  cnt_t         cnt_q, cnt_d;
  logic         exec_q, exec_d;
  logic [15:0]  pe_q, pe_d;
  logic [31:0]  since_q, since_d;
  relay_state_e known_q, known_d;
  logic         open_q, open_d;
  logic         close_q, close_d;
  logic         halt_q, halt_d;

  // configuration registers
  logic [15:0]  minv_q, minv_d;
  logic [15:0]  pulse_q, pulse_d;

  // tick inputs held across the head read
  logic         adc_q, adc_d;
  logic [15:0]  volts_q, volts_d;

  // result register
  rsp_t         out_q, out_d;
  logic         out_valid_q, out_valid_d;

  seq_state_e   state_q, state_d;
  logic         in_ready;
  logic         accept;
  logic         is_tick;
  mem_req_t     mem_req;
  cmd_t         head_cmd;
  logic [31:0]  since_inc;

  brcs_cmd_mem u_cmd_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(head_cmd)
  );

  assign accept  = cmd_i.valid && in_ready;
  assign is_tick = (func_e'(cmd_i.func) == FUNC_TICK);
  assign since_inc = (since_q == '1) ? since_q : since_q + 32'd1;

  // next state: a tick that does real work detours through the evaluate cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (accept && !halt_q && is_tick) begin
          state_d = SEQ_EVAL;
        end
      end
      SEQ_EVAL: state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = 1'b0;
    case (state_q)
      SEQ_IDLE: in_ready = !out_valid_q || rsp_o.ready;
      SEQ_EVAL: in_ready = 1'b0;
      default:  in_ready = 1'b0;
    endcase
  end

  // datapath: queue pointers, coil control, timers and the result beat
  always_comb begin
    logic done;
    logic rej;
    logic load;

    done        = 1'b0;
    rej         = 1'b0;
    load        = 1'b0;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    exec_d      = exec_q;
    pe_d        = pe_q;
    since_d     = since_q;
    known_d     = known_q;
    open_d      = open_q;
    close_d     = close_q;
    halt_d      = halt_q;
    minv_d      = minv_q;
    pulse_d     = pulse_q;
    adc_d       = adc_q;
    volts_d     = volts_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_req     = '0;

    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MIN_VOLTAGE: minv_d = cfg_data_i;
        REG_PULSE_MS:    pulse_d = cfg_data_i;
        default:         ;
      endcase
    end

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (state_q == SEQ_EVAL) begin
      load    = 1'b1;
      since_d = since_inc;
      if (cnt_q != '0) begin
        case (head_cmd.kind)
          KIND_DELAY: begin
            if (since_inc >= head_cmd.len) begin
              done = 1'b1;
            end
          end
          KIND_OPEN, KIND_CLOSE: begin
            if (exec_q) begin
              if (pe_q != 16'hFFFF) begin
                pe_d = pe_q + 16'd1;
              end
            end else if ((known_q == REL_OPEN && head_cmd.kind == KIND_OPEN) ||
                         (known_q == REL_CLOSED && head_cmd.kind == KIND_CLOSE)) begin
              // already in the wanted position
              done = 1'b1;
            end else if (adc_q && volts_q >= minv_q) begin
              if (head_cmd.kind == KIND_OPEN) begin
                open_d = 1'b1;
              end else begin
                close_d = 1'b1;
              end
              exec_d = 1'b1;
              pe_d   = '0;
            end
            // pulse end is checked in the same tick, so a zero length ends at once
            if (!done && exec_d && pe_d >= pulse_q) begin
              open_d  = 1'b0;
              close_d = 1'b0;
              known_d = (head_cmd.kind == KIND_OPEN) ? REL_OPEN : REL_CLOSED;
              done    = 1'b1;
            end
          end
          default: ;
        endcase
        if (done) begin
          head_d  = next_ptr(head_q);
          cnt_d   = cnt_q - 1'b1;
          exec_d  = 1'b0;
          pe_d    = '0;
          since_d = '0;
        end
      end
    end else if (accept) begin
      if (halt_q) begin
        load = 1'b1;
      end else begin
        case (func_e'(cmd_i.func))
          FUNC_TICK: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = head_q;
            adc_d         = cmd_i.adc_valid;
            volts_d       = cmd_i.relay_voltage;
          end
          FUNC_OPEN, FUNC_CLOSE, FUNC_DELAY: begin
            load = 1'b1;
            if (func_e'(cmd_i.func) != FUNC_DELAY || cmd_i.delay_ms != '0) begin
              if (cnt_q >= cnt_t'(QUEUE_DEPTH)) begin
                rej = 1'b1;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = tail_q;
                case (func_e'(cmd_i.func))
                  FUNC_OPEN:  mem_req.wdata = '{kind: KIND_OPEN, len: '0};
                  FUNC_CLOSE: mem_req.wdata = '{kind: KIND_CLOSE, len: '0};
                  default:    mem_req.wdata = '{kind: KIND_DELAY, len: cmd_i.delay_ms};
                endcase
                tail_d = next_ptr(tail_q);
                cnt_d  = cnt_q + 1'b1;
              end
            end
          end
          FUNC_CLEAR: begin
            load = 1'b1;
            if (exec_q) begin
              open_d  = 1'b0;
              close_d = 1'b0;
            end
            head_d = '0;
            tail_d = '0;
            cnt_d  = '0;
            exec_d = 1'b0;
            pe_d   = '0;
          end
          FUNC_PWRFAIL: begin
            load    = 1'b1;
            close_d = 1'b0;
            open_d  = 1'b1;
            halt_d  = 1'b1;
          end
          default: load = 1'b1;
        endcase
      end
    end

    if (load) begin
      out_d.open_drive   = open_d;
      out_d.close_drive  = close_d;
      out_d.relay_state  = known_d;
      out_d.queue_count  = cnt_d[3:0];
      out_d.command_done = done;
      out_d.rejected     = rej;
      out_d.halted       = halt_d;
      out_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      exec_q      <= 1'b0;
      pe_q        <= '0;
      since_q     <= '0;
      known_q     <= REL_INDET;
      open_q      <= 1'b0;
      close_q     <= 1'b0;
      halt_q      <= 1'b0;
      minv_q      <= '0;
      pulse_q     <= 16'd100;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      exec_q      <= exec_d;
      pe_q        <= pe_d;
      since_q     <= since_d;
      known_q     <= known_d;
      open_q      <= open_d;
      close_q     <= close_d;
      halt_q      <= halt_d;
      minv_q      <= minv_d;
      pulse_q     <= pulse_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    adc_q   <= adc_d;
    volts_q <= volts_d;
    out_q   <= out_d;
  end

  assign cmd_i.ready        = in_ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.open_drive   = out_q.open_drive;
  assign rsp_o.close_drive  = out_q.close_drive;
  assign rsp_o.relay_state  = out_q.relay_state;
  assign rsp_o.queue_count  = out_q.queue_count;
  assign rsp_o.command_done = out_q.command_done;
  assign rsp_o.rejected     = out_q.rejected;
  assign rsp_o.halted       = out_q.halted;

  // both coils of the relay must never be energized together
  a_coils_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(open_q && close_q))
    else $error("both relay coils driven");

  // the fill count never passes the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // evaluation returns to idle in the following cycle and always loads a result beat
  a_eval_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_EVAL |=> state_q == SEQ_IDLE && out_valid_q)
    else $error("tick evaluation did not complete");

  // halt holds until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q && open_q)
    else $error("halt released");

endmodule

// File: design/brcs_cmd_mem.sv
module brcs_cmd_mem (
  input  logic              clk_i,
  input  brcs_pkg::mem_req_t req_i,
  output brcs_pkg::cmd_t    rd_data_o
);
  import brcs_pkg::*;

  cmd_t mem [QUEUE_DEPTH];
  cmd_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
